// File: src/hld_pkg.sv
`default_nettype none
package hld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA5;
    localparam logic [BYTE_W-1:0] OVERHEAD_RST    = 8'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD    = 2'd2;

    localparam logic [POS_W-1:0] LEN_HI_POS = 17'd13;
    localparam logic [POS_W-1:0] LEN_LO_POS = 17'd14;
    localparam logic [POS_W-1:0] BODY_POS   = 17'd2;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'b001,
        PH_HUNT2 = 3'b010,
        PH_FRAME = 3'b100
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_start;
        logic              frame_end;
        logic              burst_last;
    } t_result;

    // up to two results written by one request
    typedef struct packed {
        logic    push_one;
        logic    push_two;
        t_result first;
        t_result second;
    } t_push;

endpackage
`default_nettype wire

// File: src/hld_result_queue.sv
`default_nettype none
module hld_result_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hld_pkg::t_push i_push,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_stall,
    output hld_pkg::t_result    o_head
);

    hld_pkg::t_result                 r_mem [hld_pkg::QUEUE_DEPTH];
    logic [hld_pkg::QPTR_W-1:0]       r_wr;
    logic [hld_pkg::QPTR_W-1:0]       r_rd;
    logic [hld_pkg::QCNT_W-1:0]       r_cnt;
    logic [hld_pkg::QPTR_W-1:0]       n_wr;
    logic [hld_pkg::QPTR_W-1:0]       n_rd;
    logic [hld_pkg::QCNT_W-1:0]       n_cnt;
    logic [hld_pkg::QPTR_W-1:0]       w_wr_next;
    logic                             w_pop;

    assign w_pop     = o_valid && !i_stall;
    assign w_wr_next = r_wr + hld_pkg::QPTR_W'(1);
    assign o_valid   = (r_cnt != '0);
    assign o_head    = r_mem[r_rd];
    // room for a two-result burst is required before a request is taken
    assign o_full    = (r_cnt > hld_pkg::QCNT_W'(hld_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.push_two) begin
            n_wr  = r_wr + hld_pkg::QPTR_W'(2);
            n_cnt = n_cnt + hld_pkg::QCNT_W'(2);
        end else if (i_push.push_one) begin
            n_wr  = w_wr_next;
            n_cnt = n_cnt + hld_pkg::QCNT_W'(1);
        end
        if (w_pop) begin
            n_rd  = r_rd + hld_pkg::QPTR_W'(1);
            n_cnt = n_cnt - hld_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_one || i_push.push_two) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.push_two) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

endmodule
`default_nettype wire

// File: src/header_length_deframer.sv
`default_nettype none
// Byte-stream deframer. One received byte is taken per clock while
// o_in_stall is low. Outside a frame the block hunts for the two-byte
// sync word and drops everything before it; once the sync word is seen,
// both sync bytes come out as two results (start flag on the first),
// then every frame byte comes out as one result until the total length
// (big-endian length field at frame bytes 13..14 plus length_overhead,
// never ending before byte 14) is reached, flagged with frame_end.
// burst_last marks the last result made by one input byte. The parser
// writes into a four-entry result queue, so bytes stream in at one per
// cycle while the queue has room; o_in_stall rises only while the queue
// lacks room for a two-result sync burst (three or more results
// waiting). While the output side takes one result per cycle at most two
// results ever wait, so the input never stalls; only output stalls hold
// it back. Configuration writes take effect at the next edge.
module header_length_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_frame_byte,
    output logic             o_frame_start,
    output logic             o_frame_end,
    output logic             o_burst_last
);

    logic [hld_pkg::BYTE_W-1:0] r_sync_first;
    logic [hld_pkg::BYTE_W-1:0] r_sync_second;
    logic [hld_pkg::BYTE_W-1:0] r_overhead;

    hld_pkg::t_phase            r_phase;
    hld_pkg::t_phase            n_phase;
    logic [hld_pkg::POS_W-1:0]  r_pos;
    logic [hld_pkg::POS_W-1:0]  n_pos;
    logic [hld_pkg::BYTE_W-1:0] r_len_hi;
    logic [hld_pkg::BYTE_W-1:0] n_len_hi;
    logic [hld_pkg::POS_W-1:0]  r_total;
    logic [hld_pkg::POS_W-1:0]  n_total;

    logic                       w_accept;
    logic                       w_full;
    logic [hld_pkg::POS_W-1:0]  w_sum;
    logic [hld_pkg::POS_W-1:0]  w_pos_inc;
    logic                       w_end;
    hld_pkg::t_push             w_push;
    hld_pkg::t_result           w_head;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= hld_pkg::SYNC_FIRST_RST;
            r_sync_second <= hld_pkg::SYNC_SECOND_RST;
            r_overhead    <= hld_pkg::OVERHEAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hld_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                hld_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                hld_pkg::CFG_OVERHEAD:    r_overhead    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sum     = hld_pkg::POS_W'({r_len_hi, i_rx_byte}) + hld_pkg::POS_W'(r_overhead);
    assign w_pos_inc = r_pos + hld_pkg::POS_W'(1);
    // the total is known from the low length byte on; compare against it that cycle
    assign w_end     = (r_pos >= hld_pkg::LEN_LO_POS) &&
                       (w_pos_inc >= ((r_pos == hld_pkg::LEN_LO_POS) ? w_sum : r_total));

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len_hi = r_len_hi;
        n_total  = r_total;
        w_push   = '0;
        if (w_accept) begin
            unique case (r_phase)
                hld_pkg::PH_FRAME: begin
                    if (r_pos == hld_pkg::LEN_HI_POS) begin
                        n_len_hi = i_rx_byte;
                    end
                    if (r_pos == hld_pkg::LEN_LO_POS) begin
                        n_total = w_sum;
                    end
                    w_push.push_one          = 1'b1;
                    w_push.first.frame_byte  = i_rx_byte;
                    w_push.first.frame_end   = w_end;
                    w_push.first.burst_last  = 1'b1;
                    if (w_end) begin
                        n_phase = hld_pkg::PH_HUNT1;
                        n_pos   = '0;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
                hld_pkg::PH_HUNT2: begin
                    if (i_rx_byte == r_sync_second) begin
                        w_push.push_two           = 1'b1;
                        w_push.first.frame_byte   = r_sync_first;
                        w_push.first.frame_start  = 1'b1;
                        w_push.second.frame_byte  = i_rx_byte;
                        w_push.second.burst_last  = 1'b1;
                        n_phase  = hld_pkg::PH_FRAME;
                        n_pos    = hld_pkg::BODY_POS;
                        n_len_hi = '0;
                        n_total  = '0;
                    end else if (i_rx_byte == r_sync_first) begin
                        n_phase = hld_pkg::PH_HUNT2;
                    end else begin
                        n_phase = hld_pkg::PH_HUNT1;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == r_sync_first) ? hld_pkg::PH_HUNT2
                                                          : hld_pkg::PH_HUNT1;
                    n_pos   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hld_pkg::PH_HUNT1;
            r_pos    <= '0;
            r_len_hi <= '0;
            r_total  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len_hi <= n_len_hi;
            r_total  <= n_total;
        end
    end

    hld_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_head  (w_head)
    );

    assign o_frame_byte  = w_head.frame_byte;
    assign o_frame_start = w_head.frame_start;
    assign o_frame_end   = w_head.frame_end;
    assign o_burst_last  = w_head.burst_last;

endmodule
`default_nettype wire

// File: src/hld_checker.sv
`default_nettype none
module hld_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_frame_byte,
    input wire logic       o_frame_start,
    input wire logic       o_frame_end,
    input wire logic       o_burst_last
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_frame_byte) && $stable(o_frame_start) &&
            $stable(o_frame_end) && $stable(o_burst_last))
        else $error("result changed while stalled");

    // the first sync byte is never the last of its burst
    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_start |-> !o_burst_last && !o_frame_end)
        else $error("frame start marked last");

    // the second sync byte is queued with the first and follows directly
    a_start_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_start && !i_out_stall |=>
            o_out_valid && !o_frame_start && !o_frame_end && o_burst_last)
        else $error("second sync byte missing after frame start");

    // a frame end always closes its burst
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_burst_last && !o_frame_start)
        else $error("frame end not last of burst");

endmodule

bind header_length_deframer hld_checker u_hld_checker (.*);
`default_nettype wire
